[sv/mm_pkg.sv]
// Shared constants, request and register codes, and the multiply-accumulate control type.
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int PROD_W         = 40;
    localparam int CFG_W          = 4;
    localparam int DIM_RESET      = 8;
    localparam int REQ_W          = 2;
    localparam int REG_IDX_W      = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

`default_nettype wire

[sv/mm_mac.sv]
// Two-stage multiply-accumulate unit for one dot product at a time.
`default_nettype none

module mm_mac #(
    parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic signed [ELEM_WIDTH-1:0]    a_data,
    input  wire logic signed [ELEM_WIDTH-1:0]    b_data,
    input  wire mm_pkg::mac_ctl_t                ctl,
    output logic signed [mm_pkg::PROD_W-1:0]     acc,
    output logic                                 done
);

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int XW = (PW > mm_pkg::PROD_W) ? PW : mm_pkg::PROD_W;

    logic signed [PW-1:0]             prod_full;
    logic signed [XW-1:0]             prod_ext;
    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mm_pkg::PROD_W-1:0] acc_reg;
    logic signed [mm_pkg::PROD_W-1:0] acc_next;
    mm_pkg::mac_ctl_t                 ctl_reg;
    logic                             done_reg;

    assign prod_full = a_data * b_data;
    assign prod_ext  = XW'(prod_full);
    assign acc_next  = (ctl_reg.first ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_ext[mm_pkg::PROD_W-1:0];
        if (ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.valid && ctl_reg.last;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[sv/matrix_multiply.sv]
// Fixed-point matrix product C = A * B with element loads and a compute request.
// Usage:
//   cfg_write/cfg_index/cfg_data set rows_a, inner_dim and cols_b while idle;
//   values above MAX_DIM act as MAX_DIM.
//   The input channel (in_valid/in_ready) takes one item per handshake:
//   a load of one element of A or B (ignored when outside the sizes) or a
//   compute request. A load yields nothing.
//   A compute request yields rows_a * cols_b items on the output channel
//   (out_valid/out_ready) in row-major order, the final one with last_elem.
//   Each element walks the inner dimension one term a cycle through the two
//   element memories and the multiply-accumulate unit; the next element
//   starts only once the previous dot product is done and emitted.
//   in_ready is high only while no compute request is in progress; the last
//   result may still wait in the output register while new items are taken.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset clears the sizes to 8 (or MAX_DIM) and empties the output; the
//   element memories are not cleared and must be loaded before use.
`default_nettype none

module matrix_multiply #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF,
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int DIM_W     = $clog2(MAX_DIM + 1),
    localparam int AW        = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1,
    localparam int DEPTH     = MAX_DIM * MAX_DIM
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [mm_pkg::REG_IDX_W-1:0]        cfg_index,
    input  wire logic [mm_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [mm_pkg::REQ_W-1:0]            req_type,
    input  wire logic [IDX_W-1:0]                    row_index,
    input  wire logic [IDX_W-1:0]                    col_index,
    input  wire logic signed [ELEM_WIDTH-1:0]        elem_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [IDX_W-1:0]                         out_row,
    output logic [IDX_W-1:0]                         out_col,
    output logic signed [mm_pkg::PROD_W-1:0]         prod_value,
    output logic                                     last_elem
);

    localparam int RESET_DIM = (mm_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : mm_pkg::DIM_RESET;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mm_pkg::CFG_W-1:0] v);
        if (int'(v) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] inner_dim_reg;
    logic [DIM_W-1:0] cols_b_reg;

    state_t           state_reg;
    logic [IDX_W-1:0] r_reg;
    logic [IDX_W-1:0] c_reg;
    logic [IDX_W-1:0] k_reg;
    mm_pkg::mac_ctl_t s1_ctl_reg;

    logic                             out_valid_reg;
    logic [IDX_W-1:0]                 out_row_reg;
    logic [IDX_W-1:0]                 out_col_reg;
    logic signed [mm_pkg::PROD_W-1:0] prod_value_reg;
    logic                             last_elem_reg;

    logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
    logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];
    logic signed [ELEM_WIDTH-1:0] rd_a_reg;
    logic signed [ELEM_WIDTH-1:0] rd_b_reg;

    logic                             in_fire;
    logic                             we_a;
    logic                             we_b;
    logic [AW-1:0]                    waddr;
    logic [AW-1:0]                    ra_addr;
    logic [AW-1:0]                    rb_addr;
    logic                             k_last;
    logic                             r_last;
    logic                             c_last;
    logic                             slot_free;
    logic                             zero_dot;
    logic signed [mm_pkg::PROD_W-1:0] mac_acc;
    logic                             mac_done;

    assign in_fire   = in_valid && in_ready;
    assign waddr     = AW'(row_index) * AW'(MAX_DIM) + AW'(col_index);
    assign we_a      = in_fire && (req_type == mm_pkg::REQ_LOAD_A)
                       && (DIM_W'(row_index) < rows_a_reg)
                       && (DIM_W'(col_index) < inner_dim_reg);
    assign we_b      = in_fire && (req_type == mm_pkg::REQ_LOAD_B)
                       && (DIM_W'(row_index) < inner_dim_reg)
                       && (DIM_W'(col_index) < cols_b_reg);
    assign ra_addr   = AW'(r_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign rb_addr   = AW'(k_reg) * AW'(MAX_DIM) + AW'(c_reg);
    assign k_last    = (DIM_W'(k_reg) + DIM_W'(1)) == inner_dim_reg;
    assign r_last    = (DIM_W'(r_reg) + DIM_W'(1)) == rows_a_reg;
    assign c_last    = (DIM_W'(c_reg) + DIM_W'(1)) == cols_b_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign zero_dot  = (inner_dim_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_W'(RESET_DIM);
            inner_dim_reg <= DIM_W'(RESET_DIM);
            cols_b_reg    <= DIM_W'(RESET_DIM);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mm_pkg::REG_ROWS_A:    rows_a_reg    <= clamp_dim(cfg_data);
                mm_pkg::REG_INNER_DIM: inner_dim_reg <= clamp_dim(cfg_data);
                mm_pkg::REG_COLS_B:    cols_b_reg    <= clamp_dim(cfg_data);
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[waddr] <= elem_value;
        end
        if (we_b)
        begin
            mem_b[waddr] <= elem_value;
        end
        rd_a_reg <= mem_a[ra_addr];
        rd_b_reg <= mem_b[rb_addr];
    end

    mm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .a_data (rd_a_reg),
        .b_data (rd_b_reg),
        .ctl    (s1_ctl_reg),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            r_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            s1_ctl_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            prod_value_reg <= '0;
            last_elem_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg != ST_RUN)
            begin
                s1_ctl_reg <= '0;
            end
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (req_type == mm_pkg::REQ_COMPUTE)
                        && (rows_a_reg != '0) && (cols_b_reg != '0))
                    begin
                        r_reg     <= '0;
                        c_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= zero_dot ? ST_EMIT : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    s1_ctl_reg.valid <= 1'b1;
                    s1_ctl_reg.first <= (k_reg == '0);
                    s1_ctl_reg.last  <= k_last;
                    if (k_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (mac_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_row_reg    <= r_reg;
                        out_col_reg    <= c_reg;
                        prod_value_reg <= zero_dot ? '0 : mac_acc;
                        last_elem_reg  <= r_last && c_last;
                        if (r_last && c_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            if (c_last)
                            begin
                                c_reg <= '0;
                                r_reg <= r_reg + IDX_W'(1);
                            end
                            else
                            begin
                                c_reg <= c_reg + IDX_W'(1);
                            end
                            state_reg <= zero_dot ? ST_EMIT : ST_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign prod_value = prod_value_reg;
    assign last_elem  = last_elem_reg;

`ifndef SYNTHESIS
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_DRAIN))
        else $error("dot product finished outside the drain state");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !s1_ctl_reg.valid)
        else $error("multiply pipeline busy while taking items");

    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rows_a_reg != '0) && (cols_b_reg != '0) && !zero_dot)
        else $error("sequencer running on an empty size");
`endif

endmodule

`default_nettype wire
